>>> hw/rtl/vrt_pkg.sv
// vrt_pkg: widths, vector types and saturation helpers shared by the
// vector refraction pipeline. Depends on nothing.
package vrt_pkg;

    localparam int FIELD_W       = 20;
    localparam int RATIO_W       = 18;
    localparam int MID_W         = 31;
    localparam int ACC_W         = 72;
    localparam int LEN_W         = 31;
    localparam int LSQ_W         = 2 * LEN_W;
    localparam int SQ_W          = 2 * MID_W - 1;
    localparam int EXP_W         = 5;
    localparam int EXP_MAX       = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [MID_W-1:0] mid_t;
    typedef logic [2:0][MID_W-1:0]   vec_t;
    typedef logic [2:0][FIELD_W-1:0] fvec_t;

    localparam logic signed [ACC_W-1:0] MID_MAX =
        {{(ACC_W-MID_W+1){1'b0}}, {(MID_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MID_MIN =
        {{(ACC_W-MID_W+1){1'b1}}, {(MID_W-1){1'b0}}};
    localparam mid_t FIELD_MAX = {{(MID_W-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
    localparam mid_t FIELD_MIN = {{(MID_W-FIELD_W+1){1'b1}}, {(FIELD_W-1){1'b0}}};

    function automatic mid_t sat_mid(input logic signed [ACC_W-1:0] v);
        mid_t r;
        if (v > MID_MAX)
        begin
            r = MID_MAX[MID_W-1:0];
        end
        else if (v < MID_MIN)
        begin
            r = MID_MIN[MID_W-1:0];
        end
        else
        begin
            r = v[MID_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input mid_t v);
        logic [FIELD_W-1:0] r;
        if (v > FIELD_MAX)
        begin
            r = FIELD_MAX[FIELD_W-1:0];
        end
        else if (v < FIELD_MIN)
        begin
            r = FIELD_MIN[FIELD_W-1:0];
        end
        else
        begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/vrt_isqrt.sv
// vrt_isqrt: pipelined floor integer square root, one root bit per stage,
// with a side bundle carried alongside. Depends on vrt_pkg.
module vrt_isqrt
    import vrt_pkg::*;
#(
    parameter int ROOT_W = LEN_W,
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic                valid_reg [ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [ROOT_W];
    logic [REM_W-1:0]    rem_reg   [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg   [ROOT_W];
    logic [SIDE_W-1:0]   side_reg  [ROOT_W];

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++)
        begin : g_step
            logic                valid_prev;
            logic [ROOT_W-1:0]   root_prev;
            logic [REM_W-1:0]    rem_prev;
            logic [2*ROOT_W-1:0] rad_prev;
            logic [SIDE_W-1:0]   side_prev;
            logic [REM_W-1:0]    rem_sh;
            logic [REM_W-1:0]    trial;
            logic                take;
            logic [ROOT_W-1:0]   root_next;
            logic [REM_W-1:0]    rem_next;
            logic [2*ROOT_W-1:0] rad_next;

            if (s == 0)
            begin : g_first
                assign valid_prev = in_valid;
                assign root_prev  = '0;
                assign rem_prev   = '0;
                assign rad_prev   = rad;
                assign side_prev  = in_side;
            end
            else
            begin : g_rest
                assign valid_prev = valid_reg[s-1];
                assign root_prev  = root_reg[s-1];
                assign rem_prev   = rem_reg[s-1];
                assign rad_prev   = rad_reg[s-1];
                assign side_prev  = side_reg[s-1];
            end

            always_comb
            begin
                rem_sh    = {rem_prev[ROOT_W-1:0], rad_prev[2*ROOT_W-1 -: 2]};
                trial     = {root_prev, 2'b01};
                take      = (rem_sh >= trial);
                rem_next  = take ? (rem_sh - trial) : rem_sh;
                root_next = {root_prev[ROOT_W-2:0], take};
                rad_next  = {rad_prev[2*ROOT_W-3:0], 2'b00};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[s] <= root_next;
                    rem_reg[s]  <= rem_next;
                    rad_reg[s]  <= rad_next;
                    side_reg[s] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

>>> hw/rtl/vrt_div.sv
// vrt_div: pipelined restoring divider, one quotient bit per stage, several
// lanes over a shared divisor. Depends on vrt_pkg.
module vrt_div
    import vrt_pkg::*;
#(
    parameter int QUO_W  = FRAC_BITS_DEF + 2,
    parameter int DEN_W  = LEN_W,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [DEN_W-1:0]                den,
    input  logic [LANES-1:0][DEN_W-1:0]     rem0,
    input  logic [LANES-1:0][QUO_W-1:0]     low,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic [LANES-1:0][QUO_W-1:0]     quo,
    output logic [SIDE_W-1:0]               out_side
);

    logic                        valid_reg [QUO_W];
    logic [DEN_W-1:0]            den_reg   [QUO_W];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] lq_reg    [QUO_W];
    logic [SIDE_W-1:0]           side_reg  [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_step
            logic                        valid_prev;
            logic [DEN_W-1:0]            den_prev;
            logic [LANES-1:0][DEN_W-1:0] rem_prev;
            logic [LANES-1:0][QUO_W-1:0] lq_prev;
            logic [SIDE_W-1:0]           side_prev;
            logic [LANES-1:0][DEN_W-1:0] rem_next;
            logic [LANES-1:0][QUO_W-1:0] lq_next;
            logic [DEN_W:0]              rem_sh;
            logic [DEN_W:0]              diff;
            logic                        take;

            if (s == 0)
            begin : g_first
                assign valid_prev = in_valid;
                assign den_prev   = den;
                assign rem_prev   = rem0;
                assign lq_prev    = low;
                assign side_prev  = in_side;
            end
            else
            begin : g_rest
                assign valid_prev = valid_reg[s-1];
                assign den_prev   = den_reg[s-1];
                assign rem_prev   = rem_reg[s-1];
                assign lq_prev    = lq_reg[s-1];
                assign side_prev  = side_reg[s-1];
            end

            always_comb
            begin
                rem_sh = '0;
                diff   = '0;
                take   = 1'b0;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_sh      = {rem_prev[l], lq_prev[l][QUO_W-1]};
                    diff        = rem_sh - {1'b0, den_prev};
                    take        = (rem_sh >= {1'b0, den_prev});
                    rem_next[l] = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    lq_next[l]  = {lq_prev[l][QUO_W-2:0], take};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[s]  <= den_prev;
                    rem_reg[s]  <= rem_next;
                    lq_reg[s]   <= lq_next;
                    side_reg[s] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = lq_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

>>> hw/rtl/vrt_norm.sv
// vrt_norm: pipelined normalization of a 3-vector: squared length, even
// prescale, square root and three divisions. Depends on vrt_pkg, vrt_isqrt, vrt_div.
module vrt_norm
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  vec_t              vec,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output vec_t              out_vec,
    output logic [SIDE_W-1:0] out_side
);

    localparam int QUO_W = FRAC_BITS + 2;

    typedef struct packed {
        vec_t              num;
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } sq_side_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } dv_side_t;

    logic [3:0]        vld_reg;
    logic [SQ_W-1:0]   sq_reg [3];
    vec_t              mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg, side4_reg;
    logic [LSQ_W-1:0]  lsq2_reg, lsq3_reg;
    logic [EXP_W-1:0]  exp3_reg;
    logic              zero3_reg, zero4_reg;
    logic [LSQ_W-1:0]  rad4_reg;
    vec_t              num4_reg;

    logic [SQ_W-1:0]   sq_next [3];
    vec_t              mag_next;
    logic [2:0]        neg_next;
    logic [LSQ_W-1:0]  lsq_next;
    logic [EXP_W-1:0]  exp_next;
    logic [LSQ_W-1:0]  rad_next;
    vec_t              num_next;
    logic [2*MID_W-1:0] sq_full;

    always_comb
    begin
        sq_full = '0;
        for (int i = 0; i < 3; i++)
        begin
            sq_full     = $signed(vec[i]) * $signed(vec[i]);
            sq_next[i]  = sq_full[SQ_W-1:0];
            neg_next[i] = vec[i][MID_W-1];
            mag_next[i] = vec[i][MID_W-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        lsq_next = LSQ_W'(sq_reg[0]) + LSQ_W'(sq_reg[1]) + LSQ_W'(sq_reg[2]);
        exp_next = '0;
        for (int k = 0; k < EXP_MAX; k++)
        begin
            if ((lsq2_reg >> (LSQ_W - 2 - 2 * k)) == '0)
            begin
                exp_next = exp_next + 1'b1;
            end
        end
        rad_next = lsq3_reg << {exp3_reg, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = MID_W'(mag3_reg[i] << exp3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            mag1_reg  <= mag_next;
            neg1_reg  <= neg_next;
            side1_reg <= in_side;

            lsq2_reg  <= lsq_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;

            exp3_reg  <= exp_next;
            zero3_reg <= (lsq2_reg == '0);
            lsq3_reg  <= lsq2_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            side3_reg <= side2_reg;

            rad4_reg  <= rad_next;
            num4_reg  <= num_next;
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
        end
    end

    sq_side_t           sq_in_side, sq_out_side;
    logic               sq_valid;
    logic [LEN_W-1:0]   len;

    assign sq_in_side = '{num: num4_reg, neg: neg4_reg, zero: zero4_reg, side: side4_reg};

    vrt_isqrt #(
        .ROOT_W (LEN_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[3]),
        .rad       (rad4_reg),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .root      (len),
        .out_side  (sq_out_side)
    );

    logic [2:0][LEN_W-1:0] rem0;
    logic [2:0][QUO_W-1:0] low;
    dv_side_t              dv_in_side, dv_out_side;
    logic                  dv_valid;
    logic [2:0][QUO_W-1:0] quo;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem0[i] = LEN_W'(sq_out_side.num[i] >> 2);
            low[i]  = {sq_out_side.num[i][1:0], {FRAC_BITS{1'b0}}};
        end
    end

    assign dv_in_side = '{neg: sq_out_side.neg, zero: sq_out_side.zero,
                          side: sq_out_side.side};

    vrt_div #(
        .QUO_W  (QUO_W),
        .DEN_W  (LEN_W),
        .LANES  (3),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .den       (len),
        .rem0      (rem0),
        .low       (low),
        .in_side   (dv_in_side),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (dv_out_side)
    );

    logic              out_valid_reg;
    vec_t              out_vec_reg;
    vec_t              out_vec_next;
    logic [SIDE_W-1:0] out_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_out_side.zero)
            begin
                out_vec_next[i] = '0;
            end
            else if (dv_out_side.neg[i])
            begin
                out_vec_next[i] = MID_W'(~MID_W'(quo[i]) + 1'b1);
            end
            else
            begin
                out_vec_next[i] = MID_W'(quo[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vec_reg  <= out_vec_next;
            out_side_reg <= dv_out_side.side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

>>> hw/rtl/vrt_bend.sv
// vrt_bend: pipelined refraction core: cosine, perpendicular part, k test,
// reflection path and the square root term. Depends on vrt_pkg, vrt_isqrt.
module vrt_bend
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  vec_t               u,
    input  fvec_t              nrm,
    input  logic [RATIO_W-1:0] ratio,
    output logic               out_valid,
    output vec_t               t,
    output vec_t               refl,
    output logic               tir
);

    localparam int PU_W   = MID_W + FIELD_W;
    localparam int SUM_W  = PU_W + 2;
    localparam int PR_W   = MID_W + 1 + FIELD_W;
    localparam int PP_W   = RATIO_W + 1 + MID_W;
    localparam int QS_W   = SQ_W + 2;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int PS_W   = ROOT_W + 1 + FIELD_W;
    localparam mid_t ONE_Q = MID_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic  tir;
        vec_t  perp;
        vec_t  refl;
        fvec_t nrm;
    } bsq_side_t;

    logic [7:0] vld_reg;
    logic [1:0] tail_vld_reg;

    logic signed [PU_W-1:0] pu_reg [3];
    logic signed [PU_W-1:0] pc_reg [3];
    logic signed [PR_W-1:0] pr_reg [3];
    logic signed [PP_W-1:0] pp_reg [3];
    logic [SQ_W-1:0]        q_reg  [3];
    logic signed [PS_W-1:0] ps_reg [3];
    mid_t                   cos_reg, d_reg, k_reg;
    vec_t  u1_reg, u2_reg, u3_reg, s_reg, r4_reg, r5_reg, r6_reg, r7_reg, r8_reg;
    vec_t  perp6_reg, perp7_reg, perp8_reg, perp10_reg, r10_reg, t_reg, r11_reg;
    fvec_t n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg, n7_reg, n8_reg;
    logic [RATIO_W-1:0] ra1_reg, ra2_reg, ra3_reg, ra4_reg;
    logic  tir10_reg, tir11_reg;

    logic signed [PU_W-1:0]  pu_next [3];
    logic signed [PU_W-1:0]  pc_next [3];
    logic signed [PR_W-1:0]  pr_next [3];
    logic signed [PP_W-1:0]  pp_next [3];
    logic [SQ_W-1:0]         q_next  [3];
    logic signed [PS_W-1:0]  ps_next [3];
    logic signed [SUM_W-1:0] dot_sum;
    logic signed [ACC_W-1:0] neg_acc;
    mid_t                    cos_t, cos_next, d_next, k_next;
    vec_t                    s_next, r_next, perp_next, t_next;
    logic [2*MID_W-1:0]      sq_full;
    logic [QS_W-1:0]         qsum;

    bsq_side_t          sq_in_side, sq_out_side;
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    logic [2*ROOT_W-1:0] rad;

    always_comb
    begin
        sq_full = '0;
        for (int i = 0; i < 3; i++)
        begin
            pu_next[i]   = $signed(u[i]) * $signed(nrm[i]);
            pc_next[i]   = cos_reg * $signed(n2_reg[i]);
            pr_next[i]   = $signed({d_reg, 1'b0}) * $signed(n2_reg[i]);
            s_next[i]    = sat_mid(ACC_W'($signed(u3_reg[i]))
                                   + ACC_W'(pc_reg[i] >>> FRAC_BITS));
            r_next[i]    = sat_mid(ACC_W'($signed(u3_reg[i]))
                                   - ACC_W'(pr_reg[i] >>> FRAC_BITS));
            pp_next[i]   = $signed({1'b0, ra4_reg}) * $signed(s_reg[i]);
            perp_next[i] = sat_mid(ACC_W'(pp_reg[i] >>> FRAC_BITS));
            sq_full      = $signed(perp6_reg[i]) * $signed(perp6_reg[i]);
            q_next[i]    = sq_full[SQ_W-1:0];
            ps_next[i]   = $signed({1'b0, sq_root}) * $signed(sq_out_side.nrm[i]);
            t_next[i]    = sat_mid(ACC_W'($signed(perp10_reg[i]))
                                   - ACC_W'(ps_reg[i] >>> FRAC_BITS));
        end
        dot_sum  = SUM_W'(pu_reg[0]) + SUM_W'(pu_reg[1]) + SUM_W'(pu_reg[2]);
        neg_acc  = -ACC_W'(dot_sum);
        cos_t    = sat_mid(neg_acc >>> FRAC_BITS);
        cos_next = (cos_t > ONE_Q) ? ONE_Q : cos_t;
        d_next   = sat_mid(ACC_W'(dot_sum >>> FRAC_BITS));
        qsum     = QS_W'(q_reg[0]) + QS_W'(q_reg[1]) + QS_W'(q_reg[2]);
        k_next   = sat_mid(ACC_W'(ONE_Q) - $signed(ACC_W'(qsum >> FRAC_BITS)));
        rad      = k_reg[MID_W-1] ? '0 : {1'b0, k_reg[FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            tail_vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[6:0], in_valid};
            tail_vld_reg <= {tail_vld_reg[0], sq_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg     <= pu_next;
            u1_reg     <= u;
            n1_reg     <= nrm;
            ra1_reg    <= ratio;

            cos_reg    <= cos_next;
            d_reg      <= d_next;
            u2_reg     <= u1_reg;
            n2_reg     <= n1_reg;
            ra2_reg    <= ra1_reg;

            pc_reg     <= pc_next;
            pr_reg     <= pr_next;
            u3_reg     <= u2_reg;
            n3_reg     <= n2_reg;
            ra3_reg    <= ra2_reg;

            s_reg      <= s_next;
            r4_reg     <= r_next;
            n4_reg     <= n3_reg;
            ra4_reg    <= ra3_reg;

            pp_reg     <= pp_next;
            r5_reg     <= r4_reg;
            n5_reg     <= n4_reg;

            perp6_reg  <= perp_next;
            r6_reg     <= r5_reg;
            n6_reg     <= n5_reg;

            q_reg      <= q_next;
            perp7_reg  <= perp6_reg;
            r7_reg     <= r6_reg;
            n7_reg     <= n6_reg;

            k_reg      <= k_next;
            perp8_reg  <= perp7_reg;
            r8_reg     <= r7_reg;
            n8_reg     <= n7_reg;

            ps_reg     <= ps_next;
            perp10_reg <= sq_out_side.perp;
            r10_reg    <= sq_out_side.refl;
            tir10_reg  <= sq_out_side.tir;

            t_reg      <= t_next;
            r11_reg    <= r10_reg;
            tir11_reg  <= tir10_reg;
        end
    end

    assign sq_in_side = '{tir: k_reg[MID_W-1], perp: perp8_reg, refl: r8_reg, nrm: n8_reg};

    vrt_isqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(bsq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[7]),
        .rad       (rad),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_out_side)
    );

    assign out_valid = tail_vld_reg[1];
    assign t         = t_reg;
    assign refl      = r11_reg;
    assign tir       = tir11_reg;

endmodule

>>> hw/rtl/vector_refract_with_tir.sv
// vector_refract_with_tir: top level of the refraction pipeline with total
// internal reflection. Depends on vrt_pkg, vrt_norm, vrt_bend.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_ready   | incident_x/y/z, normal_x/y/z, index_ratio
//  output  | out_valid / out_ready | out_x/y/z, total_reflection
//
// one item per cycle sustained while the skid entry stays empty; the pipe holds two
// 31-step root pipelines, two FRAC_BITS+2 step divider pipelines and a
// FRAC_BITS+1 step root for the transmitted term
// all stages advance together; an output register plus one skid entry
// keep the input open while a result waits, and stall the pipe when both fill
// reset clears valid bits and the output/skid flags only
module vector_refract_with_tir
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] incident_x,
    input  logic [FIELD_W-1:0] incident_y,
    input  logic [FIELD_W-1:0] incident_z,
    input  logic [FIELD_W-1:0] normal_x,
    input  logic [FIELD_W-1:0] normal_y,
    input  logic [FIELD_W-1:0] normal_z,
    input  logic [RATIO_W-1:0] index_ratio,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] out_x,
    output logic [FIELD_W-1:0] out_y,
    output logic [FIELD_W-1:0] out_z,
    output logic               total_reflection
);

    typedef struct packed {
        fvec_t              nrm;
        logic [RATIO_W-1:0] ratio;
    } n1_side_t;

    typedef struct packed {
        logic tir;
        vec_t refl;
    } n2_side_t;

    logic     adv;
    vec_t     inc_vec;
    n1_side_t n1_in_side, n1_out_side;
    logic     n1_valid;
    vec_t     u_vec;

    logic     bd_valid;
    vec_t     t_vec, r_vec;
    logic     bd_tir;

    n2_side_t n2_in_side, n2_out_side;
    logic     n2_valid;
    vec_t     n2_vec;

    logic     out_valid_reg, skid_valid_reg;
    logic     push;
    vec_t     sel_vec;
    logic [FIELD_W-1:0] px_next, py_next, pz_next;
    logic [FIELD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [FIELD_W-1:0] skid_x_reg, skid_y_reg, skid_z_reg;
    logic               out_tir_reg, skid_tir_reg;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    assign inc_vec[0] = MID_W'($signed(incident_x));
    assign inc_vec[1] = MID_W'($signed(incident_y));
    assign inc_vec[2] = MID_W'($signed(incident_z));
    assign n1_in_side = '{nrm: {normal_z, normal_y, normal_x}, ratio: index_ratio};

    vrt_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(n1_side_t))
    ) u_norm_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .vec       (inc_vec),
        .in_side   (n1_in_side),
        .out_valid (n1_valid),
        .out_vec   (u_vec),
        .out_side  (n1_out_side)
    );

    vrt_bend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_bend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n1_valid),
        .u         (u_vec),
        .nrm       (n1_out_side.nrm),
        .ratio     (n1_out_side.ratio),
        .out_valid (bd_valid),
        .t         (t_vec),
        .refl      (r_vec),
        .tir       (bd_tir)
    );

    assign n2_in_side = '{tir: bd_tir, refl: r_vec};

    vrt_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(n2_side_t))
    ) u_norm_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (bd_valid),
        .vec       (t_vec),
        .in_side   (n2_in_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_side  (n2_out_side)
    );

    assign push    = adv && n2_valid;
    assign sel_vec = n2_out_side.tir ? n2_out_side.refl : n2_vec;
    assign px_next = sat_field($signed(sel_vec[0]));
    assign py_next = sat_field($signed(sel_vec[1]));
    assign pz_next = sat_field($signed(sel_vec[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_x_reg   <= skid_x_reg;
                out_y_reg   <= skid_y_reg;
                out_z_reg   <= skid_z_reg;
                out_tir_reg <= skid_tir_reg;
            end
            else
            begin
                out_x_reg   <= px_next;
                out_y_reg   <= py_next;
                out_z_reg   <= pz_next;
                out_tir_reg <= n2_out_side.tir;
            end
        end
        else if (push)
        begin
            skid_x_reg   <= px_next;
            skid_y_reg   <= py_next;
            skid_z_reg   <= pz_next;
            skid_tir_reg <= n2_out_side.tir;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_x            = out_x_reg;
    assign out_y            = out_y_reg;
    assign out_z            = out_z_reg;
    assign total_reflection = out_tir_reg;

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item without output item");

    // a taken result drains the skid entry
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid)
        else $error("skid item not moved to output");

    // a finished item arriving at a stalled output lands in the skid entry
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && !skid_valid_reg && n2_valid |=> skid_valid_reg)
        else $error("finished item lost at stalled output");

endmodule
